// ===== design/srx_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the serial frame receiver.
package srx_pkg;

  localparam int unsigned SRX_MAX_FRAME = 255;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_LEN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_OFS = 4'd1;

  localparam logic [2:0] KIND_DISCARD = 3'd0;
  localparam logic [2:0] KIND_SYNC    = 3'd1;
  localparam logic [2:0] KIND_HEADER  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_CRC     = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_BODY,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [7:0]  byte_position;
    logic [2:0]  byte_kind;
    logic        frame_end;
    logic        frame_good;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } srx_result_t;

  // MSB-first CRC-16, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [15:0] SYNC_CRC = crc16_byte(crc16_byte(CRC_INIT, SYNC_FIRST), SYNC_SECOND);

endpackage

// ===== design/serial_frame_receiver_crc16_top.sv =====
// Top level of the serial frame receiver with sync hunt and CRC-16 check.
// One received byte is taken per clock while in_stall is low and yields
// exactly one result item: the byte echoed with its position and kind,
// end/good flags and the running good and bad frame counts. Sustained rate is
// one item per cycle without out_stall; each result is registered. The longest
// path is the byte-wide CRC-16 update (eight chained shift/xor steps) plus the
// length checks feeding the state registers. A two-entry output buffer sits
// after the frame logic, so input keeps flowing while a result waits;
// in_stall rises only when both entries are held. The frame hunts for 0xAA
// 0x55, reads the total length at the configured header offset, collects the
// payload, then checks a little-endian CRC-16 (poly 0x1021, init 0xFFFF) over
// all frame bytes from the first sync byte. Bad lengths and overruns past
// MAX_FRAME abort the frame and count it as bad. Config writes (index 0:
// header length, index 1: length byte offset) are always ready and take
// effect on the next byte; writes to other indexes are ignored.
module serial_frame_receiver_crc16_top #(
  parameter int unsigned MAX_FRAME = srx_pkg::SRX_MAX_FRAME
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte_value,
  output logic [7:0]                     out_byte_position,
  output logic [2:0]                     out_byte_kind,
  output logic                           out_frame_end,
  output logic                           out_frame_good,
  output logic [31:0]                    out_good_frames,
  output logic [31:0]                    out_bad_frames,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srx_pkg::*;

  logic        accept;
  logic        buf_full;
  srx_result_t core_res;
  srx_result_t buf_res;

  // config port never back-pressures
  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;

  srx_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (core_res)
  );

  srx_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .din       (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (buf_res)
  );

  assign out_byte_value    = buf_res.byte_value;
  assign out_byte_position = buf_res.byte_position;
  assign out_byte_kind     = buf_res.byte_kind;
  assign out_frame_end     = buf_res.frame_end;
  assign out_frame_good    = buf_res.frame_good;
  assign out_good_frames   = buf_res.good_frames;
  assign out_bad_frames    = buf_res.bad_frames;

endmodule

// ===== design/srx_core.sv =====
// Frame state machine, CRC accumulation, counters and config registers.
module srx_core #(
  parameter int unsigned MAX_FRAME = srx_pkg::SRX_MAX_FRAME
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [7:0]                       rx_byte,
  input  logic                             cfg_we,
  input  logic [srx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srx_pkg::CFG_DATA_W-1:0]   cfg_data,
  output srx_pkg::srx_result_t             res
);
  import srx_pkg::*;

  localparam logic [8:0] MAX_W = 9'(MAX_FRAME);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  body_count_r, body_count_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic [31:0] good_total_r, good_total_nxt;
  logic [31:0] bad_total_r, bad_total_nxt;
  logic [6:0]  hdr_len_r;
  logic [5:0]  len_ofs_r;

  logic [5:0]  eo;
  logic [8:0]  n;
  logic        is_len_byte;
  logic [7:0]  fl_eff;
  logic        len_bad;
  logic        body_done;
  logic        body_abort;
  logic        crc_match;
  logic [15:0] crc_upd;

  // shared decode for the body and CRC phases
  always_comb begin
    eo          = (len_ofs_r < 6'd2) ? 6'd2 : len_ofs_r;
    n           = {1'b0, body_count_r} + 9'd1;
    is_len_byte = (body_count_r == {2'b00, eo});
    fl_eff      = is_len_byte ? rx_byte : frame_length_r;
    len_bad     = (rx_byte < {1'b0, hdr_len_r}) || ({1'b0, rx_byte} > MAX_W) ||
                  (rx_byte <= {2'b00, eo});
    body_done   = (body_count_r >= {2'b00, eo}) && (n == {1'b0, fl_eff});
    body_abort  = (is_len_byte && len_bad) || (!body_done && (n >= MAX_W));
    crc_match   = ({rx_byte, crc_low_r} == crc_r);
    crc_upd     = crc16_byte(crc_r, rx_byte);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE:  phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC : PH_IDLE;
      PH_SYNC:  phase_nxt = (rx_byte == SYNC_SECOND) ? PH_BODY : PH_IDLE;
      PH_BODY: begin
        if (body_abort) begin
          phase_nxt = PH_IDLE;
        end else if (body_done) begin
          phase_nxt = PH_CRCLO;
        end
      end
      PH_CRCLO: phase_nxt = PH_CRCHI;
      PH_CRCHI: phase_nxt = PH_IDLE;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    body_count_nxt   = body_count_r;
    frame_length_nxt = frame_length_r;
    crc_nxt          = crc_r;
    crc_low_nxt      = crc_low_r;
    good_total_nxt   = good_total_r;
    bad_total_nxt    = bad_total_r;
    res.byte_value    = rx_byte;
    res.byte_position = 8'd0;
    res.byte_kind     = KIND_DISCARD;
    res.frame_end     = 1'b0;
    res.frame_good    = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == SYNC_FIRST) begin
          res.byte_kind = KIND_SYNC;
        end
      end
      PH_SYNC: begin
        if (rx_byte == SYNC_SECOND) begin
          res.byte_kind     = KIND_SYNC;
          res.byte_position = 8'd1;
          body_count_nxt    = 8'd2;
          crc_nxt           = SYNC_CRC;
        end
      end
      PH_BODY: begin
        res.byte_position = body_count_r;
        res.byte_kind     = (body_count_r < {1'b0, hdr_len_r}) ? KIND_HEADER : KIND_PAYLOAD;
        crc_nxt           = crc_upd;
        frame_length_nxt  = fl_eff;
        body_count_nxt    = n[7:0];
        if (body_abort) begin
          res.frame_end = 1'b1;
          bad_total_nxt = bad_total_r + 32'd1;
        end
      end
      PH_CRCLO: begin
        res.byte_position = body_count_r;
        res.byte_kind     = KIND_CRC;
        crc_low_nxt       = rx_byte;
        body_count_nxt    = n[7:0];
      end
      PH_CRCHI: begin
        res.byte_position = body_count_r;
        res.byte_kind     = KIND_CRC;
        res.frame_end     = 1'b1;
        if (crc_match) begin
          res.frame_good = 1'b1;
          good_total_nxt = good_total_r + 32'd1;
        end else begin
          bad_total_nxt = bad_total_r + 32'd1;
        end
      end
      default: ;
    endcase
    res.good_frames = good_total_nxt;
    res.bad_frames  = bad_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      body_count_r   <= 8'd0;
      frame_length_r <= 8'd0;
      crc_r          <= CRC_INIT;
      crc_low_r      <= 8'd0;
      good_total_r   <= 32'd0;
      bad_total_r    <= 32'd0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      body_count_r   <= body_count_nxt;
      frame_length_r <= frame_length_nxt;
      crc_r          <= crc_nxt;
      crc_low_r      <= crc_low_nxt;
      good_total_r   <= good_total_nxt;
      bad_total_r    <= bad_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_len_r <= 7'd16;
      len_ofs_r <= 6'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HDR_LEN: hdr_len_r <= cfg_data[6:0];
        CFG_LEN_OFS: len_ofs_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  a_good_has_end: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.frame_good |-> res.frame_end)
    else $error("good flag without frame end");

  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> good_total_r == $past(good_total_r) + {31'd0, $past(res.frame_good)})
    else $error("good counter out of step with good frames");

  a_sync_enters_body: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_SYNC && rx_byte == SYNC_SECOND
    |=> phase_r == PH_BODY && body_count_r == 8'd2 && crc_r == SYNC_CRC)
    else $error("sync pair did not start a frame body");

endmodule

// ===== design/srx_obuf.sv =====
// Two-entry output buffer: result register plus skid entry.
module srx_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  srx_pkg::srx_result_t din,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srx_pkg::srx_result_t dout
);
  import srx_pkg::*;

  srx_result_t ent0_r, ent0_nxt;
  srx_result_t ent1_r, ent1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign dout      = ent0_r;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          ent0_nxt = din;
        end else begin
          ent1_nxt = din;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        ent0_nxt = ent1_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          ent0_nxt = din;
        end else begin
          ent0_nxt = ent1_r;
          ent1_nxt = din;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full output buffer");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("pop did not drain an entry");

endmodule
